/* sv/mcfr_pkg.sv */
package mcfr_pkg;

  localparam int PAYLOAD_DEPTH = 512;
  localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] START_SHORT = 8'd2;
  localparam logic [7:0] START_LONG  = 8'd3;
  localparam logic [7:0] END_MARK    = 8'd3;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [0:0] {
    CFG_RECEIVE_ENABLE = 1'b0,
    CFG_DELIVER_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_END  = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_TOO_LONG = 2'd3
  } frame_status_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic       is_read;
    logic       is_start_short;
    logic       is_start_long;
    logic       is_end_mark;
    logic [7:0] rx_byte;
    logic [8:0] read_index;
  } req_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/mcfr_front.sv */
module mcfr_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_req_type,
  input  logic [7:0]     in_rx_byte,
  input  logic [8:0]     in_read_index,
  input  logic           receive_enable,
  output logic           push_valid,
  input  logic           push_ready,
  output mcfr_pkg::req_t push_data
);

  logic is_read;

  assign is_read  = (in_req_type == mcfr_pkg::REQ_READ);
  assign in_ready = push_ready;

  // bytes arriving while disabled are taken and dropped here
  assign push_valid = in_valid && (is_read || receive_enable);

  always_comb begin
    push_data.is_read        = is_read;
    push_data.is_start_short = (in_rx_byte == mcfr_pkg::START_SHORT);
    push_data.is_start_long  = (in_rx_byte == mcfr_pkg::START_LONG);
    push_data.is_end_mark    = (in_rx_byte == mcfr_pkg::END_MARK);
    push_data.rx_byte        = in_rx_byte;
    push_data.read_index     = in_read_index;
  end

endmodule

/* sv/mcfr_queue.sv */
module mcfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcfr_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mcfr_pkg::req_t pop_data
);

  mcfr_pkg::req_t                entry_r [mcfr_pkg::Q_DEPTH];
  logic [mcfr_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mcfr_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mcfr_pkg::Q_CW-1:0]     count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (count_r != mcfr_pkg::Q_CW'(mcfr_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/mcfr_back.sv */
module mcfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           deliver_enable,
  input  logic           req_valid,
  output logic           req_ready,
  input  mcfr_pkg::req_t req_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_is_read_reply,
  output logic [1:0]     out_frame_status,
  output logic [7:0]     out_cmd_code,
  output logic [15:0]    out_payload_length,
  output logic [7:0]     out_read_data
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  localparam int CW = mcfr_pkg::CNT_W;
  localparam int AW = mcfr_pkg::IDX_W;

  phase_t            phase_r, phase_nxt;
  logic [15:0]       decl_len_r, decl_len_nxt;
  logic [CW-1:0]     stored_r, stored_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       rx_crc_r, rx_crc_nxt;
  logic [7:0]        cmd_r, cmd_nxt;

  // result stage 1 (waits for the memory read), then output register
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_reply_r, s1_reply_nxt;
  logic [1:0]        s1_status_r, s1_status_nxt;
  logic [7:0]        s1_cmd_r, s1_cmd_nxt;
  logic [15:0]       s1_len_r, s1_len_nxt;
  logic              s1_rd_ok_r, s1_rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_reply_r, out_reply_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [7:0]        out_cmd_r, out_cmd_nxt;
  logic [15:0]       out_len_r, out_len_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic [7:0]        mem [mcfr_pkg::PAYLOAD_DEPTH];
  logic [7:0]        mem_q_r;
  logic              wr_en, rd_en;

  logic              take, produce, s1_adv;
  logic [15:0]       len_full;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign req_ready = !s1_valid_r || s1_adv;
  assign take      = req_valid && req_ready;
  assign len_full  = {decl_len_r[15:8], req_data.rx_byte};

  always_comb begin
    phase_nxt     = phase_r;
    decl_len_nxt  = decl_len_r;
    stored_nxt    = stored_r;
    crc_nxt       = crc_r;
    rx_crc_nxt    = rx_crc_r;
    cmd_nxt       = cmd_r;
    produce       = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    // stage 1 holds its request until it moves on
    s1_reply_nxt  = s1_reply_r;
    s1_status_nxt = s1_status_r;
    s1_cmd_nxt    = s1_cmd_r;
    s1_len_nxt    = s1_len_r;
    s1_rd_ok_nxt  = s1_rd_ok_r;

    if (take) begin
      s1_reply_nxt  = 1'b0;
      s1_status_nxt = mcfr_pkg::ST_GOOD;
      s1_cmd_nxt    = 8'h00;
      s1_len_nxt    = 16'h0000;
      s1_rd_ok_nxt  = 1'b0;
      if (req_data.is_read) begin
        produce      = 1'b1;
        rd_en        = 1'b1;
        s1_reply_nxt = 1'b1;
        s1_rd_ok_nxt = (CW'(req_data.read_index) < stored_r);
      end else begin
        unique case (phase_r)
          PH_LEN_HI: begin
            decl_len_nxt = {req_data.rx_byte, 8'h00};
            phase_nxt    = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            decl_len_nxt = len_full;
            if (len_full > 16'(mcfr_pkg::PAYLOAD_DEPTH)) begin
              phase_nxt     = PH_HUNT;
              produce       = deliver_enable;
              s1_status_nxt = mcfr_pkg::ST_TOO_LONG;
              s1_len_nxt    = len_full;
            end else if (len_full == 16'h0000) begin
              phase_nxt = PH_CRC_HI;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            wr_en = 1'b1;
            if (stored_r == '0) begin
              cmd_nxt = req_data.rx_byte;
            end
            crc_nxt    = mcfr_pkg::crc16_step(crc_r, req_data.rx_byte);
            stored_nxt = stored_r + 1'b1;
            if (16'(stored_nxt) >= decl_len_r) begin
              phase_nxt = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            rx_crc_nxt = {req_data.rx_byte, 8'h00};
            phase_nxt  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            rx_crc_nxt = {rx_crc_r[15:8], req_data.rx_byte};
            phase_nxt  = PH_END;
          end
          PH_END: begin
            phase_nxt = PH_HUNT;
            produce   = deliver_enable;
            if (!req_data.is_end_mark) begin
              s1_status_nxt = mcfr_pkg::ST_BAD_END;
            end else if (rx_crc_r != crc_r) begin
              s1_status_nxt = mcfr_pkg::ST_CRC_ERR;
            end else begin
              s1_status_nxt = mcfr_pkg::ST_GOOD;
            end
            s1_cmd_nxt = (decl_len_r != 16'h0000) ? cmd_r : 8'h00;
            s1_len_nxt = decl_len_r;
          end
          default: begin
            phase_nxt = PH_HUNT;
            if (req_data.is_start_short || req_data.is_start_long) begin
              decl_len_nxt = 16'h0000;
              stored_nxt   = '0;
              crc_nxt      = 16'h0000;
              rx_crc_nxt   = 16'h0000;
              phase_nxt    = req_data.is_start_short ? PH_LEN_LO : PH_LEN_HI;
            end
          end
        endcase
      end
    end

    if (take && produce) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    out_reply_nxt  = out_reply_r;
    out_status_nxt = out_status_r;
    out_cmd_nxt    = out_cmd_r;
    out_len_nxt    = out_len_r;
    out_data_nxt   = out_data_r;
    if (s1_adv) begin
      out_valid_nxt  = 1'b1;
      out_reply_nxt  = s1_reply_r;
      out_status_nxt = s1_status_r;
      out_cmd_nxt    = s1_cmd_r;
      out_len_nxt    = s1_len_r;
      out_data_nxt   = (s1_reply_r && s1_rd_ok_r) ? mem_q_r : 8'h00;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      decl_len_r  <= '0;
      stored_r    <= '0;
      crc_r       <= '0;
      rx_crc_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      decl_len_r  <= decl_len_nxt;
      stored_r    <= stored_nxt;
      crc_r       <= crc_nxt;
      rx_crc_r    <= rx_crc_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    s1_reply_r   <= s1_reply_nxt;
    s1_status_r  <= s1_status_nxt;
    s1_cmd_r     <= s1_cmd_nxt;
    s1_len_r     <= s1_len_nxt;
    s1_rd_ok_r   <= s1_rd_ok_nxt;
    out_reply_r  <= out_reply_nxt;
    out_status_r <= out_status_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_len_r    <= out_len_nxt;
    out_data_r   <= out_data_nxt;
  end

  // payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stored_r[AW-1:0]] <= req_data.rx_byte;
    end
    if (rd_en) begin
      mem_q_r <= mem[AW'(req_data.read_index)];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_read_reply  = out_reply_r;
  assign out_frame_status   = out_status_r;
  assign out_cmd_code       = out_cmd_r;
  assign out_payload_length = out_len_r;
  assign out_read_data      = out_data_r;

endmodule

/* sv/motor_ctrl_frame_receiver_core.sv */
// A request passes through the queue, result stage 1 and the output register.
// Throughput: one request per cycle (bytes and reads alike) unless out_ready
// stalls the output. Payload memory: one write port, one registered read port.
// Reset: rst_n synchronous, active low; clears phase, counters, CRC, queue and
// output valid. The payload memory is not cleared and needs no startup pass.
module motor_ctrl_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [8:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_read_reply,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_cmd_code,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_read_data
);

  logic           receive_enable_r;
  logic           deliver_enable_r;
  logic           push_valid, push_ready;
  mcfr_pkg::req_t push_data;
  logic           pop_valid, pop_ready;
  mcfr_pkg::req_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receive_enable_r <= 1'b0;
      deliver_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (mcfr_pkg::cfg_reg_t'(cfg_index))
        mcfr_pkg::CFG_RECEIVE_ENABLE: receive_enable_r <= cfg_data;
        mcfr_pkg::CFG_DELIVER_ENABLE: deliver_enable_r <= cfg_data;
      endcase
    end
  end

  mcfr_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_rx_byte     (in_rx_byte),
    .in_read_index  (in_read_index),
    .receive_enable (receive_enable_r),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  mcfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mcfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .deliver_enable     (deliver_enable_r),
    .req_valid          (pop_valid),
    .req_ready          (pop_ready),
    .req_data           (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_read_reply  (out_is_read_reply),
    .out_frame_status   (out_frame_status),
    .out_cmd_code       (out_cmd_code),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data)
  );

endmodule

/* sv/mcfr_checker.sv */
module mcfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_read_reply,
  input logic [1:0]  out_frame_status,
  input logic [7:0]  out_cmd_code,
  input logic [15:0] out_payload_length,
  input logic [7:0]  out_read_data
);

  localparam logic [15:0] DEPTH16 = 16'(mcfr_pkg::PAYLOAD_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_read_reply) &&
    $stable(out_frame_status) && $stable(out_cmd_code) &&
    $stable(out_payload_length) && $stable(out_read_data))
    else $error("result changed while stalled");

  a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_read_reply |->
    out_frame_status == mcfr_pkg::ST_GOOD && out_cmd_code == 8'h00 &&
    out_payload_length == 16'h0000)
    else $error("read reply carries frame fields");

  a_event_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_read_reply |-> out_read_data == 8'h00)
    else $error("frame event carries read data");

  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_read_reply && out_frame_status == mcfr_pkg::ST_TOO_LONG |->
    out_payload_length > DEPTH16 && out_cmd_code == 8'h00)
    else $error("too-long event with bad length or command");

  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_read_reply && out_frame_status != mcfr_pkg::ST_TOO_LONG |->
    out_payload_length <= DEPTH16)
    else $error("completed frame longer than buffer");

endmodule

bind motor_ctrl_frame_receiver_core mcfr_checker u_mcfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_is_read_reply  (out_is_read_reply),
  .out_frame_status   (out_frame_status),
  .out_cmd_code       (out_cmd_code),
  .out_payload_length (out_payload_length),
  .out_read_data      (out_read_data)
);

/* tb/testbench.sv */
module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_END     = 3'd6
  } rx_phase_t;

  typedef struct packed {
    logic                    is_reply;
    mcfr_pkg::frame_status_t status;
    logic [7:0]              cmd;
    logic [15:0]             len;
    logic [7:0]              data;
  } frame_event_t;

  // Tracks the deframer state and holds the frame events / read replies still owed.
  class frame_scoreboard;
    logic         rx_en;
    logic         dl_en;
    rx_phase_t    phase;
    logic [15:0]  decl_len;
    logic [15:0]  n_stored;
    logic [15:0]  crc;
    logic [15:0]  rx_crc;
    logic [7:0]   store [mcfr_pkg::PAYLOAD_DEPTH];
    frame_event_t pending [$];
    int unsigned  errors;

    function new();
      rx_en    = 1'b0;
      dl_en    = 1'b1;
      phase    = PH_HUNT;
      decl_len = '0;
      n_stored = '0;
      crc      = '0;
      rx_crc   = '0;
      errors   = 0;
    endfunction

    // CRC-16/XMODEM, one byte, MSB first
    static function logic [15:0] crc_next(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void set_reg(mcfr_pkg::cfg_reg_t r, logic v);
      if (r == mcfr_pkg::CFG_RECEIVE_ENABLE) begin
        rx_en = v;
      end else begin
        dl_en = v;
      end
    endfunction

    function void note_request(mcfr_pkg::req_kind_t kind, logic [7:0] b, logic [8:0] idx);
      frame_event_t ev;
      ev = '0;
      if (kind == mcfr_pkg::REQ_READ) begin
        ev.is_reply = 1'b1;
        if (16'(idx) < n_stored) begin
          ev.data = store[idx];
        end
        pending.push_back(ev);
        return;
      end
      if (!rx_en) begin
        return;
      end
      case (phase)
        PH_LEN_HI: begin
          decl_len = {b, 8'h00};
          phase    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          decl_len = {decl_len[15:8], b};
          if (decl_len > 16'(mcfr_pkg::PAYLOAD_DEPTH)) begin
            phase = PH_HUNT;
            if (dl_en) begin
              ev.status = mcfr_pkg::ST_TOO_LONG;
              ev.len    = decl_len;
              pending.push_back(ev);
            end
          end else begin
            phase = (decl_len == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (n_stored < 16'(mcfr_pkg::PAYLOAD_DEPTH)) begin
            store[n_stored[8:0]] = b;
          end
          crc      = crc_next(crc, b);
          n_stored = n_stored + 16'd1;
          if (n_stored >= decl_len) begin
            phase = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          rx_crc = {b, 8'h00};
          phase  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc = {rx_crc[15:8], b};
          phase  = PH_END;
        end
        PH_END: begin
          phase = PH_HUNT;
          if (dl_en) begin
            ev.cmd = (decl_len != 16'd0) ? store[0] : 8'h00;
            ev.len = decl_len;
            // end byte is judged before the CRC
            if (b != mcfr_pkg::END_MARK) begin
              ev.status = mcfr_pkg::ST_BAD_END;
            end else if (rx_crc != crc) begin
              ev.status = mcfr_pkg::ST_CRC_ERR;
            end else begin
              ev.status = mcfr_pkg::ST_GOOD;
            end
            pending.push_back(ev);
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == mcfr_pkg::START_SHORT || b == mcfr_pkg::START_LONG) begin
            decl_len = '0;
            n_stored = '0;
            crc      = '0;
            rx_crc   = '0;
            phase    = (b == mcfr_pkg::START_SHORT) ? PH_LEN_LO : PH_LEN_HI;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic reply, logic [1:0] status, logic [7:0] cmd,
                               logic [15:0] len, logic [7:0] data);
      frame_event_t ev;
      if (pending.size() == 0) begin
        $display("%0t: result with none pending: reply %0b status %0d cmd %0h len %0d data %0h",
                 $time, reply, status, cmd, len, data);
        errors++;
        return;
      end
      ev = pending.pop_front();
      compare_field("is_read_reply", 16'(ev.is_reply), 16'(reply));
      compare_field("frame_status", 16'(ev.status), 16'(status));
      compare_field("cmd_code", 16'(ev.cmd), 16'(cmd));
      compare_field("payload_length", ev.len, len);
      compare_field("read_data", 16'(ev.data), 16'(data));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [8:0]  in_read_index = 9'h000;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_is_read_reply;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_cmd_code;
  logic [15:0] out_payload_length;
  logic [7:0]  out_read_data;

  frame_scoreboard sb;
  bit              gaps_on = 1'b1;
  bit              stalls_on = 1'b1;
  bit              mix_reads = 1'b0;
  int unsigned     n_sent = 0;
  int unsigned     cycles = 0;

  motor_ctrl_frame_receiver_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_read_reply  (out_is_read_reply),
    .out_frame_status   (out_frame_status),
    .out_cmd_code       (out_cmd_code),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("motor_ctrl_frame_receiver_core regression: fail");
      $finish;
    end
  end

  // request noted before result check so a same-edge pair stays ordered
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(mcfr_pkg::req_kind_t'(in_req_type), in_rx_byte, in_read_index);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_is_read_reply, out_frame_status, out_cmd_code,
                        out_payload_length, out_read_data);
      end
    end
  end

  always begin
    @(posedge clk);
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_req(mcfr_pkg::req_kind_t kind, logic [7:0] b, logic [8:0] idx);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_rx_byte    <= b;
    in_read_index <= idx;
    // in_ready only moves at rising edges; its mid-cycle value decides the next edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    n_sent++;
  endtask

  task automatic send_read(logic [8:0] idx);
    send_req(mcfr_pkg::REQ_READ, 8'($urandom), idx);
  endtask

  task automatic send_byte(logic [7:0] b);
    if (mix_reads && $urandom_range(0, 15) == 0) begin
      send_read(9'($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 15)));
    end
    send_req(mcfr_pkg::REQ_BYTE, b, 9'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // frames with no event may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(mcfr_pkg::cfg_reg_t r, logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic send_frame(logic [15:0] len, bit long_hdr, bit bad_crc, bit bad_end);
    logic [15:0] c;
    logic [7:0]  b;
    bit          hdr_long;
    c        = '0;
    hdr_long = long_hdr || (len > 16'd255);
    send_byte(hdr_long ? mcfr_pkg::START_LONG : mcfr_pkg::START_SHORT);
    if (hdr_long) begin
      send_byte(len[15:8]);
    end
    send_byte(len[7:0]);
    if (len > 16'(mcfr_pkg::PAYLOAD_DEPTH)) begin
      return;
    end
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      c = frame_scoreboard::crc_next(c, b);
      send_byte(b);
    end
    if (bad_crc) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_byte(c[15:8]);
    send_byte(c[7:0]);
    if (bad_end) begin
      do b = 8'($urandom); while (b == mcfr_pkg::END_MARK);
      send_byte(b);
    end else begin
      send_byte(mcfr_pkg::END_MARK);
    end
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [15:0] len;
    goal = n_sent + n;
    while (n_sent < goal) begin
      pick = $urandom_range(0, 99);
      len  = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                               : $urandom_range(0, 12));
      if (pick < 62) begin
        send_frame(len, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end else if (pick < 72) begin
        send_frame(len, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
      end else if (pick < 80) begin
        send_frame(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 85) begin
        send_frame(16'($urandom_range(mcfr_pkg::PAYLOAD_DEPTH + 1, 65535)), 1'b1, 1'b0, 1'b0);
      end else if (pick < 91) begin
        // truncated frame; whatever follows is taken as the rest of the frame
        send_byte(mcfr_pkg::START_SHORT);
        send_byte(len[7:0]);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_read(9'($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 15)));
        end
      end
    end
  endtask

  initial begin
    logic [15:0] c;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // receiver is off out of reset: byte ignored, read still answered
    send_byte(mcfr_pkg::START_SHORT);
    send_read(9'd0);
    write_reg(mcfr_pkg::CFG_RECEIVE_ENABLE, 1'b1);
    write_reg(mcfr_pkg::CFG_DELIVER_ENABLE, 1'b1);

    // zero-length frame goes straight to the CRC
    send_frame(16'd0, 1'b0, 1'b0, 1'b0);
    send_byte(mcfr_pkg::START_LONG);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    c = frame_scoreboard::crc_next(16'h0000, 8'hFF);
    send_byte(c[15:8]);
    send_byte(c[7:0]);
    send_byte(mcfr_pkg::END_MARK);
    send_read(9'd0);
    send_read(9'd1);
    // oversized lengths: just past the buffer and the maximum
    send_frame(16'(mcfr_pkg::PAYLOAD_DEPTH + 1), 1'b1, 1'b0, 1'b0);
    send_frame(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_frame(16'd0, 1'b0, 1'b0, 1'b1);
    // restart clears what a read can see
    send_byte(mcfr_pkg::START_SHORT);
    send_read(9'd0);

    mix_reads = 1'b1;
    random_traffic(25);
    write_reg(mcfr_pkg::CFG_DELIVER_ENABLE, 1'b0);
    random_traffic(15);
    write_reg(mcfr_pkg::CFG_DELIVER_ENABLE, 1'b1);
    write_reg(mcfr_pkg::CFG_RECEIVE_ENABLE, 1'b0);
    random_traffic(10);
    write_reg(mcfr_pkg::CFG_RECEIVE_ENABLE, 1'b1);

    // long frame past the 256 mark, then read across it and past its end
    send_frame(16'd300, 1'b1, 1'b0, 1'b0);
    send_read(9'd299);
    send_read(9'd298);
    send_read(9'd256);
    send_read(9'd300);
    send_read(9'd0);
    drain();

    random_traffic(15);
    write_reg(mcfr_pkg::CFG_DELIVER_ENABLE, 1'b0);
    write_reg(mcfr_pkg::CFG_RECEIVE_ENABLE, 1'b0);
    random_traffic(10);
    write_reg(mcfr_pkg::CFG_RECEIVE_ENABLE, 1'b1);
    write_reg(mcfr_pkg::CFG_DELIVER_ENABLE, 1'b1);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_traffic(30);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("motor_ctrl_frame_receiver_core regression: pass");
    end else begin
      $display("motor_ctrl_frame_receiver_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mcfr_pkg.sv
sv/mcfr_front.sv
sv/mcfr_queue.sv
sv/mcfr_back.sv
sv/motor_ctrl_frame_receiver_core.sv
sv/mcfr_checker.sv
tb/testbench.sv
